FILE: hw/rtl/assert_macros.svh
// assertion helpers for the tilt inclinometer rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form: explicit clock and active-low reset
`define ATI_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// house form: module clock clk_i, reset rst_ni
`define ATI_ASSERT_CLK(name, prop, msg) \
  `ATI_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

FILE: hw/rtl/ati_pkg.sv
// shared types, widths and constants of the tilt inclinometer
// used by ati_isqrt, ati_cordic and accel_tilt_inclinometer_top
`default_nettype none

package ati_pkg;

  localparam int InW      = 16;  // raw accel count width
  localparam int RadW     = 48;  // radicand (x*x + z*z) << 16
  localparam int RootW    = 24;  // floor square root of the radicand
  localparam int XyW      = 27;  // cordic vector component width
  localparam int AngW     = 25;  // cordic angle accumulator, q15 degrees
  localparam int AtanW    = 21;
  localparam int AtanLen  = 24;
  localparam int AtanIdxW = 5;
  localparam int NumLanes = 2;   // lane 0 roll, lane 1 pitch
  localparam int RollW    = 16;
  localparam int PitchW   = 17;
  localparam int RollOffW = 15;
  localparam int PitchOffW = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgRollOffset  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPitchOffset = 2'd1;

  localparam int LaneRoll  = 0;
  localparam int LanePitch = 1;

  typedef logic signed [XyW-1:0]  xy_t;
  typedef logic signed [AngW-1:0] ang_t;

  localparam ang_t Deg90  = 25'sd2949120;
  localparam ang_t Deg180 = 25'sd5898240;
  localparam ang_t RoundHalf = 25'sd128;

  // sample fields that ride along with the square root
  typedef struct packed {
    logic signed [InW-1:0] x;
    logic signed [InW-1:0] y;
    logic signed [InW-1:0] z;
    logic                  inv;
  } ati_side_t;

  // atan(2^-i) in degrees, q15, rounded to nearest
  function automatic logic [AtanW-1:0] atan_q15(input logic [AtanIdxW-1:0] idx);
    logic [AtanW-1:0] v;
    case (idx)
      5'd0:  v = 21'd1474560;
      5'd1:  v = 21'd870484;
      5'd2:  v = 21'd459940;
      5'd3:  v = 21'd233473;
      5'd4:  v = 21'd117189;
      5'd5:  v = 21'd58652;
      5'd6:  v = 21'd29333;
      5'd7:  v = 21'd14667;
      5'd8:  v = 21'd7334;
      5'd9:  v = 21'd3667;
      5'd10: v = 21'd1833;
      5'd11: v = 21'd917;
      5'd12: v = 21'd458;
      5'd13: v = 21'd229;
      5'd14: v = 21'd115;
      5'd15: v = 21'd57;
      5'd16: v = 21'd29;
      5'd17: v = 21'd14;
      5'd18: v = 21'd7;
      5'd19: v = 21'd4;
      5'd20: v = 21'd2;
      5'd21: v = 21'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ati_isqrt.sv
// pipelined floor square root, one result bit per register stage
// depends on ati_pkg; carries the sample fields alongside
`default_nettype none

module ati_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [ati_pkg::RadW-1:0]     rad_i,
  input  ati_pkg::ati_side_t           side_i,
  output logic                         valid_o,
  output logic [ati_pkg::RootW-1:0]    root_o,
  output ati_pkg::ati_side_t           side_o
);
  import ati_pkg::*;

  logic             vld_q  [RootW];
  logic [RadW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  ati_side_t        side_q [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_step
    localparam int K = RootW - 1 - s;  // root bit decided here

    logic             p_vld;
    logic [RadW-1:0]  p_rem;
    logic [RootW-1:0] p_root;
    ati_side_t        p_side;
    logic [RadW-1:0]  trial;
    logic             take;

    if (s == 0) begin : g_first
      assign p_vld  = valid_i;
      assign p_rem  = rad_i;
      assign p_root = '0;
      assign p_side = side_i;
    end else begin : g_next
      assign p_vld  = vld_q[s-1];
      assign p_rem  = rem_q[s-1];
      assign p_root = root_q[s-1];
      assign p_side = side_q[s-1];
    end

    // (root + 2^k)^2 - root^2
    assign trial = (RadW'(p_root) << (K + 1)) | (RadW'(1) << (2 * K));
    assign take  = (p_rem >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= p_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? (p_rem - trial) : p_rem;
        root_q[s] <= take ? (p_root | (RootW'(1) << K)) : p_root;
        side_q[s] <= p_side;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

`default_nettype wire

FILE: hw/rtl/ati_cordic.sv
// two-lane pipelined vectoring cordic giving atan2(y, x) in q15 degrees
// depends on ati_pkg (widths, angle table); one stage per iteration
`default_nettype none

module ati_cordic #(
  parameter int NUM_ITER = 16
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic                                       tag_i,
  input  ati_pkg::xy_t  [ati_pkg::NumLanes-1:0]      x_i,
  input  ati_pkg::xy_t  [ati_pkg::NumLanes-1:0]      y_i,
  output logic                                       valid_o,
  output logic                                       tag_o,
  output ati_pkg::ang_t [ati_pkg::NumLanes-1:0]      ang_o
);
  import ati_pkg::*;

  logic vld_q [NUM_ITER+1];
  logic tag_q [NUM_ITER+1];
  xy_t  x_q   [NUM_ITER+1][NumLanes];
  xy_t  y_q   [NUM_ITER+1][NumLanes];
  ang_t a_q   [NUM_ITER+1][NumLanes];

  // stage 0: quadrant fold and the axis special cases
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_pre
    xy_t  xin;
    xy_t  yin;
    xy_t  pre_x;
    xy_t  pre_y;
    ang_t pre_a;

    assign xin = x_i[l];
    assign yin = y_i[l];

    always_comb begin
      pre_x = xin;
      pre_y = yin;
      pre_a = '0;
      if (xin == 0 && yin == 0) begin
        pre_a = '0;
      end else if (xin < 0) begin
        pre_a = (yin >= 0) ? Deg180 : -Deg180;
        pre_x = -xin;
        pre_y = -yin;
      end else if (xin == 0) begin
        // on the y axis: exact angle, zero residue holds it
        pre_a = (yin > 0) ? Deg90 : -Deg90;
        pre_y = '0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0][l] <= pre_x;
        y_q[0][l] <= pre_y;
        a_q[0][l] <= pre_a;
      end
    end
  end

  // micro-rotation stages
  for (genvar s = 1; s <= NUM_ITER; s++) begin : g_iter
    localparam int Sh = s - 1;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tag_q[s] <= tag_q[s-1];
      end
    end

    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      xy_t  px;
      xy_t  py;
      ang_t pa;
      xy_t  dx;
      xy_t  dy;
      ang_t step;
      xy_t  nx;
      xy_t  ny;
      ang_t na;

      assign px   = x_q[s-1][l];
      assign py   = y_q[s-1][l];
      assign pa   = a_q[s-1][l];
      assign dx   = py >>> Sh;
      assign dy   = px >>> Sh;
      assign step = ang_t'(atan_q15(AtanIdxW'(Sh)));

      always_comb begin
        nx = px;
        ny = py;
        na = pa;
        if (py > 0) begin
          nx = px + dx;
          ny = py - dy;
          na = pa + step;
        end else if (py < 0) begin
          nx = px - dx;
          ny = py + dy;
          na = pa - step;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[s][l] <= nx;
          y_q[s][l] <= ny;
          a_q[s][l] <= na;
        end
      end
    end
  end

  assign valid_o = vld_q[NUM_ITER];
  assign tag_o   = tag_q[NUM_ITER];

  for (genvar l = 0; l < NumLanes; l++) begin : g_out
    assign ang_o[l] = a_q[NUM_ITER][l];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/accel_tilt_inclinometer_top.sv
// tilt inclinometer top: squares, pipelined square root, two-lane cordic,
// offset removal; depends on ati_pkg, ati_isqrt, ati_cordic, assert_macros.svh
//
//   channel   handshake                 payload
//   ------    ---------------------     ----------------------------------------
//   input     in_valid_i / in_stall_o   accel_x_i, accel_y_i, accel_z_i
//   output    out_valid_o / out_stall_i angle_valid_o, roll_angle_o, pitch_angle_o
//   config    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// one sample per cycle while in_stall_o is low. register stages in order: three for
// input, squares and sum, 24 for the square root (one root bit per stage), one
// quadrant fold, one per cordic iteration, one output register.
// reset clears the pipeline valid bits (not angle_valid_o) and both offsets.
// a stall from the sink freezes every stage only while a result waits in the
// output register; bubbles ahead of it keep moving otherwise.
`default_nettype none

module accel_tilt_inclinometer_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ati_pkg::InW-1:0]        accel_x_i,
  input  logic signed [ati_pkg::InW-1:0]        accel_y_i,
  input  logic signed [ati_pkg::InW-1:0]        accel_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  angle_valid_o,
  output logic signed [ati_pkg::RollW-1:0]      roll_angle_o,
  output logic signed [ati_pkg::PitchW-1:0]     pitch_angle_o,
  input  logic                                  cfg_we_i,
  input  logic [ati_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [ati_pkg::CfgDataW-1:0]          cfg_wdata_i
);
  import ati_pkg::*;

  localparam int NumIter = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;

  logic ce;

  // offsets
  logic signed [RollOffW-1:0]  roll_off_q;
  logic signed [PitchOffW-1:0] pitch_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_off_q  <= '0;
      pitch_off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRollOffset:  roll_off_q  <= cfg_wdata_i[RollOffW-1:0];
        CfgPitchOffset: pitch_off_q <= cfg_wdata_i[PitchOffW-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: capture the sample
  logic      vld1_q;
  ati_side_t side1_q;
  ati_side_t side1_d;

  always_comb begin
    side1_d.x   = accel_x_i;
    side1_d.y   = accel_y_i;
    side1_d.z   = accel_z_i;
    side1_d.inv = (accel_y_i == '0) && (accel_z_i == '0);
  end

  // stage 2: squares
  logic                  vld2_q;
  ati_side_t             side2_q;
  logic signed [31:0]    xsq;
  logic signed [31:0]    zsq;
  logic [30:0]           xx2_q;
  logic [30:0]           zz2_q;

  assign xsq = side1_q.x * side1_q.x;
  assign zsq = side1_q.z * side1_q.z;

  // stage 3: radicand
  logic            vld3_q;
  ati_side_t       side3_q;
  logic [31:0]     sum_sq;
  logic [RadW-1:0] rad3_q;

  assign sum_sq = {1'b0, xx2_q} + {1'b0, zz2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (ce) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      side1_q <= side1_d;
      side2_q <= side1_q;
      xx2_q   <= xsq[30:0];
      zz2_q   <= zsq[30:0];
      side3_q <= side2_q;
      rad3_q  <= {sum_sq, 16'h0000};
    end
  end

  // square root of the x-z hypotenuse, scaled by 2^8
  logic             sq_vld;
  logic [RootW-1:0] sq_root;
  ati_side_t        sq_side;

  ati_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ce),
    .valid_i (vld3_q),
    .rad_i   (rad3_q),
    .side_i  (side3_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // lane 0: roll = atan2(y, hyp); lane 1: pitch = atan2(z, x)
  xy_t  [NumLanes-1:0] cx;
  xy_t  [NumLanes-1:0] cy;
  logic                c_vld;
  logic                c_inv;
  ang_t [NumLanes-1:0] c_ang;

  assign cx[LaneRoll]  = xy_t'(sq_root);
  assign cy[LaneRoll]  = {{(XyW-InW-8){sq_side.y[InW-1]}}, sq_side.y, 8'h00};
  assign cx[LanePitch] = {{(XyW-InW-8){sq_side.x[InW-1]}}, sq_side.x, 8'h00};
  assign cy[LanePitch] = {{(XyW-InW-8){sq_side.z[InW-1]}}, sq_side.z, 8'h00};

  ati_cordic #(
    .NUM_ITER (NumIter)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ce),
    .valid_i (sq_vld),
    .tag_i   (sq_side.inv),
    .x_i     (cx),
    .y_i     (cy),
    .valid_o (c_vld),
    .tag_o   (c_inv),
    .ang_o   (c_ang)
  );

  // output stage: round q15 to 1/128 degree, remove offsets
  ang_t                      roll_rnd;
  ang_t                      pitch_rnd;
  logic                      out_valid_q;
  logic                      angle_valid_q;
  logic                      angle_valid_d;
  logic signed [RollW-1:0]   roll_q;
  logic signed [RollW-1:0]   roll_d;
  logic signed [PitchW-1:0]  pitch_q;
  logic signed [PitchW-1:0]  pitch_d;

  assign roll_rnd  = c_ang[LaneRoll] + RoundHalf;
  assign pitch_rnd = c_ang[LanePitch] + RoundHalf;

  always_comb begin
    angle_valid_d = !c_inv;
    roll_d  = roll_rnd[8 +: RollW] - {roll_off_q[RollOffW-1], roll_off_q};
    pitch_d = pitch_rnd[8 +: PitchW] - {pitch_off_q[PitchOffW-1], pitch_off_q};
    if (c_inv) begin
      roll_d  = '0;
      pitch_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ce) begin
      out_valid_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      angle_valid_q <= angle_valid_d;
      roll_q        <= roll_d;
      pitch_q       <= pitch_d;
    end
  end

  // the pipe only halts while a finished result is held by the sink
  assign in_stall_o = out_valid_q & out_stall_i;
  assign ce         = !in_stall_o;

  assign out_valid_o   = out_valid_q;
  assign angle_valid_o = angle_valid_q;
  assign roll_angle_o  = roll_q;
  assign pitch_angle_o = pitch_q;

  `include "assert_macros.svh"

  `ATI_ASSERT_CLK(a_invalid_zero, ((out_valid_o && !angle_valid_o) |-> (roll_angle_o == '0 && pitch_angle_o == '0)), "invalid sample with nonzero angles")
  `ATI_ASSERT_CLK(a_stall_only_when_full, (in_stall_o |-> (out_valid_o && out_stall_i)), "input stalled with no result held")
  `ATI_ASSERT_CLK(a_pitch_off_write, ((cfg_we_i && cfg_idx_i == CfgPitchOffset) |=> (pitch_off_q == $past(cfg_wdata_i))), "pitch offset write lost")

endmodule

`default_nettype wire
